FILE: rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// Load cell reader package
// Shared types and constants for the load cell converter serial reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

    // Width of the emitted reading and its saturation value
    localparam int NET_BITS = 24;
    localparam logic [NET_BITS-1:0] NET_MAX = '1;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HALF_PERIOD   = 3'd0,
        CFG_GAIN_PULSES   = 3'd1,
        CFG_AVERAGE_COUNT = 3'd2,
        CFG_ZERO_OFFSET   = 3'd3,
        CFG_POWER_DOWN    = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [15:0] HALF_PERIOD_RST   = 16'd20;
    localparam logic [1:0]  GAIN_PULSES_RST   = 2'd1;
    localparam logic [7:0]  AVERAGE_COUNT_RST = 8'd1;

    // Live configuration handed to the front and back ends
    typedef struct packed {
        logic [15:0]         half_period_ticks;
        logic [1:0]          gain_pulses;
        logic [7:0]          average_count;
        logic [NET_BITS-1:0] zero_offset;
        logic                power_down;
    } cfg_t;

    // Serial clock phase of the front end
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // Back end sequencer state
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_DIVIDE = 2'd1,
        BK_FINISH = 2'd2
    } back_state_t;

endpackage

FILE: rtl/lcr_front.sv
// ----------------------------------------------------------------------------
// Load cell reader front end
// Runs the serial clock sequencer once per tick, shifts in sample bits,
// accumulates samples and tags the tick that completes an average.
// ----------------------------------------------------------------------------
module lcr_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int SUM_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcr_pkg::cfg_t       cfg,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  logic                dout_level,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [SUM_BITS+1:0] push_data   // sum, done flag, sclk level
);
    import lcr_pkg::*;

    localparam int IDX_BITS = $clog2(SAMPLE_BITS + 4);

    typedef logic [SUM_BITS-1:0] sum_t;

    phase_t                 phase_reg, phase_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [15:0]            cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    sum_t                   sum_reg, sum_next;
    logic [7:0]             taken_reg, taken_next;

    logic                   sclk;
    logic                   done;
    sum_t                   sum_out;
    logic                   accept;

    assign accept     = tick_valid && push_ready;
    assign tick_ready = push_ready;
    assign push_valid = tick_valid;
    assign push_data  = {sclk, done, sum_out};

    // Advance the sequencer by one tick
    always_comb
    begin
        logic [15:0]            half;
        logic [7:0]             navg;
        logic [IDX_BITS-1:0]    total;
        logic                   half_done;
        logic [SAMPLE_BITS-1:0] sample;
        sum_t                   sum_new;
        logic [7:0]             taken_new;

        half      = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
        navg      = (cfg.average_count == 8'd0) ? 8'd1 : cfg.average_count;
        total     = IDX_BITS'(SAMPLE_BITS) + IDX_BITS'(cfg.gain_pulses);
        half_done = 1'b0;
        sample    = '0;
        sum_new   = sum_reg;
        taken_new = taken_reg;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        sum_next   = sum_reg;
        taken_next = taken_reg;
        sclk       = 1'b0;
        done       = 1'b0;
        sum_out    = sum_reg;

        if (cfg.power_down)
        begin
            // Hold the clock high and abandon any conversion
            phase_next = PH_IDLE;
            idx_next   = '0;
            cnt_next   = '0;
            sclk       = 1'b1;
        end
        else
        begin
            // Start a conversion when the data line signals ready
            if (phase_reg == PH_IDLE && !dout_level)
            begin
                phase_next = PH_HIGH;
                idx_next   = '0;
                cnt_next   = '0;
                shift_next = '0;
            end
            half_done = ({1'b0, cnt_next} + 17'd1) >= {1'b0, half};
            case (phase_next)
                PH_HIGH:
                begin
                    sclk = 1'b1;
                    if (half_done)
                    begin
                        cnt_next = '0;
                        if (idx_next < IDX_BITS'(SAMPLE_BITS))
                        begin
                            shift_next = {shift_next[SAMPLE_BITS-2:0], dout_level};
                        end
                        phase_next = PH_LOW;
                    end
                    else
                    begin
                        cnt_next = cnt_next + 16'd1;
                    end
                end
                PH_LOW:
                begin
                    if (half_done)
                    begin
                        cnt_next = '0;
                        if ((idx_next + IDX_BITS'(1)) < total)
                        begin
                            idx_next   = idx_next + IDX_BITS'(1);
                            phase_next = PH_HIGH;
                        end
                        else
                        begin
                            // Last pulse: fold the sample into the running sum
                            sample     = shift_next ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                            sum_new    = sum_reg + sum_t'(sample);
                            taken_new  = taken_reg + 8'd1;
                            phase_next = PH_IDLE;
                            idx_next   = '0;
                            sum_next   = sum_new;
                            taken_next = taken_new;
                            sum_out    = sum_new;
                            if (taken_new >= navg)
                            begin
                                done       = 1'b1;
                                sum_next   = '0;
                                taken_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_next + 16'd1;
                    end
                end
                default:
                begin
                    sclk = 1'b0;
                end
            endcase
        end
    end

    // Sequencer and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
        end
    end

endmodule

FILE: rtl/lcr_queue.sv
// ----------------------------------------------------------------------------
// Load cell reader tick queue
// Two-entry queue that decouples the tick sequencer from the divider.
// ----------------------------------------------------------------------------
module lcr_queue #(
    parameter int WIDTH = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import lcr_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/lcr_back.sv
// ----------------------------------------------------------------------------
// Load cell reader back end
// Divides completed sums by the sample count one bit per cycle, removes the
// zero offset and drives the registered output transfer.
// ----------------------------------------------------------------------------
module lcr_back #(
    parameter int SUM_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcr_pkg::cfg_t       cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  logic [SUM_BITS+1:0] pop_data,      // sum, done flag, sclk level
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,  // [0] sclk_level, [24:1] net_reading
    output logic                m_axis_tuser   // [0] result_valid
);
    import lcr_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS);

    typedef logic [SUM_BITS-1:0] sum_t;

    back_state_t         state_reg, state_next;
    sum_t                quo_reg, quo_next;
    logic [7:0]          rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                sclk_hold_reg, sclk_hold_next;
    logic [NET_BITS-1:0] last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_sclk_reg, out_sclk_next;
    logic                out_flag_reg, out_flag_next;
    logic [NET_BITS-1:0] out_net_reg, out_net_next;

    logic                out_free;
    logic [7:0]          navg;
    logic [8:0]          trial;
    logic                ge;
    sum_t                off_ext;
    sum_t                diff;
    logic [NET_BITS-1:0] net;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop_ready = (state_reg == BK_IDLE) && out_free;
    assign navg      = (cfg.average_count == 8'd0) ? 8'd1 : cfg.average_count;

    // One restoring division step
    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign ge    = trial >= {1'b0, navg};

    // Offset removal with floor at zero and saturation
    assign off_ext = sum_t'(cfg.zero_offset);
    assign diff    = quo_reg - off_ext;
    always_comb
    begin
        if (quo_reg <= off_ext)
        begin
            net = '0;
        end
        else if (diff > sum_t'(NET_MAX))
        begin
            net = NET_MAX;
        end
        else
        begin
            net = diff[NET_BITS-1:0];
        end
    end

    // Sequence: take an entry, divide if it completes an average, load output
    always_comb
    begin
        logic [8:0] rem_sub;

        rem_sub        = trial - {1'b0, navg};
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        sclk_hold_next = sclk_hold_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_sclk_next  = out_sclk_reg;
        out_flag_next  = out_flag_reg;
        out_net_next   = out_net_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    if (pop_data[SUM_BITS])
                    begin
                        state_next     = BK_DIVIDE;
                        quo_next       = pop_data[SUM_BITS-1:0];
                        rem_next       = '0;
                        cnt_next       = '0;
                        sclk_hold_next = pop_data[SUM_BITS+1];
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_sclk_next  = pop_data[SUM_BITS+1];
                        out_flag_next  = 1'b0;
                        out_net_next   = last_reg;
                    end
                end
            end
            BK_DIVIDE:
            begin
                rem_next = ge ? rem_sub[7:0] : trial[7:0];
                quo_next = {quo_reg[SUM_BITS-2:0], ge};
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sclk_next  = sclk_hold_reg;
                    out_flag_next  = 1'b1;
                    out_net_next   = net;
                    last_next      = net;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        sclk_hold_reg <= sclk_hold_next;
        out_sclk_reg  <= out_sclk_next;
        out_flag_reg  <= out_flag_next;
        out_net_reg   <= out_net_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32 - NET_BITS - 1){1'b0}}, out_net_reg, out_sclk_reg};
    assign m_axis_tuser  = out_flag_reg;

endmodule

FILE: rtl/load_cell_adc_serial_reader_unit.sv
// ----------------------------------------------------------------------------
// Load cell converter serial reader
// Two-wire bridge converter reader: clocking, averaging and offset removal.
// ----------------------------------------------------------------------------
// Each input transfer is one timing tick carrying the converter data-line
// level, and each produces exactly one output transfer with the serial clock
// level for that tick, a new-reading flag and the current net reading. A tick
// completing an average is held in the back end by the one-bit-per-cycle
// divider that divides the sum by the sample count; a two-entry queue
// between the tick sequencer and the divider lets the sequencer keep taking
// ticks until the queue fills. Configuration is written through cfg_we /
// cfg_index / cfg_data and must only change while no tick is outstanding.
module load_cell_adc_serial_reader_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int SUM_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] dout_level
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // [0] sclk_level,
                                                              // [24:1] net_reading
    output logic                               m_axis_tuser,  // [0] result_valid
    input  logic                               cfg_we,
    input  logic [lcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lcr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lcr_pkg::*;

    localparam int ENTRY_BITS = SUM_BITS + 2;

    cfg_t                  cfg_reg;
    logic                  push_valid;
    logic                  push_ready;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [ENTRY_BITS-1:0] pop_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.gain_pulses       <= GAIN_PULSES_RST;
            cfg_reg.average_count     <= AVERAGE_COUNT_RST;
            cfg_reg.zero_offset       <= '0;
            cfg_reg.power_down        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD:   cfg_reg.half_period_ticks <= cfg_data[15:0];
                CFG_GAIN_PULSES:   cfg_reg.gain_pulses       <= cfg_data[1:0];
                CFG_AVERAGE_COUNT: cfg_reg.average_count     <= cfg_data[7:0];
                CFG_ZERO_OFFSET:   cfg_reg.zero_offset       <= cfg_data[NET_BITS-1:0];
                CFG_POWER_DOWN:    cfg_reg.power_down        <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    lcr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .tick_valid  (s_axis_tvalid),
        .tick_ready  (s_axis_tready),
        .dout_level  (s_axis_tdata[0]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    lcr_queue #(
        .WIDTH     (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    lcr_back #(
        .SUM_BITS      (SUM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
